// ===== sv/lal_pkg.sv =====
// shared types and constants for the two anchor line locator
`timescale 1ns / 1ps
package lal_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W = 24;
  localparam int DIST_W  = 24;
  localparam int POS_W   = 26;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int ROOT_STEPS = DIFF_W;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [2:0] {
    U_SQX, U_SQY, U_SUM, U_SQRT, U_DIV, U_DONE
  } unit_state_t;

  typedef enum logic [1:0] {
    MODE_MEAN = 2'd0,
    MODE_A    = 2'd1,
    MODE_B    = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AX   = 3'd0,
    REG_AY   = 3'd1,
    REG_BX   = 3'd2,
    REG_BY   = 3'd3,
    REG_MODE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic done;
    logic coincide;
  } unit_status_t;
endpackage

// ===== sv/two_anchor_line_locator.sv =====
// top level of the two anchor line locator
// Places a tag on the line through anchors A and B from its two measured
// distances. Anchors and estimate mode must be written by the user on the
// cfg_ port only while the block is idle; the block itself does not
// enforce this. Each write restarts the unit vector sequencer, which holds
// in_ready low after the write until it is done (two squares and a sum, 25
// root steps, one load and FRAC_BITS+26 divider steps, both axes together).
// in_ carries dist_a/dist_b, out_ gives pos_x/pos_y/anchors_coincide.
// The pipeline has three register stages: out_valid follows the input
// transfer through v1_r, v2_r and v3_r. One item per cycle is taken once
// the sequencer is done and while the receiver does not stall; each axis
// has three register stages (multiply, estimate select, round and clamp).
// After reset the anchors are zero and the sequencer runs once before
// in_ready rises. When the receiver stalls, the whole pipeline holds, the
// result stays on out_ and in_ready drops until out_ready returns; nothing
// is lost or repeated.
`timescale 1ns / 1ps
module two_anchor_line_locator import lal_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [COORD_W-1:0]          cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [DIST_W-1:0]           in_dist_a,
  input  logic [DIST_W-1:0]           in_dist_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [POS_W-1:0]     out_pos_x,
  output logic signed [POS_W-1:0]     out_pos_y,
  output logic                        out_anchors_coincide
);
  localparam int UW = FRAC_BITS + 2;

  logic signed [COORD_W-1:0] ax_r, ay_r, bx_r, by_r;
  mode_t mode_r;
  logic v1_r, v2_r, v3_r;
  logic c1_r, c2_r, c3_r;
  logic en;
  logic [UW-1:0] ux, uy;
  unit_status_t ust;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0; ay_r <= '0; bx_r <= '0; by_r <= '0;
      mode_r <= MODE_MEAN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AX:   ax_r <= cfg_data;
        REG_AY:   ay_r <= cfg_data;
        REG_BX:   bx_r <= cfg_data;
        REG_BY:   by_r <= cfg_data;
        REG_MODE: mode_r <= mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  lal_unit #(.FRAC_BITS(FRAC_BITS)) u_unit (
    .clk(clk), .rst_n(rst_n), .start(cfg_we),
    .a_x(ax_r), .a_y(ay_r), .b_x(bx_r), .b_y(by_r),
    .u_x(ux), .u_y(uy), .status(ust)
  );

  // pipeline advance and valid bits
  assign en = !v3_r || out_ready;
  assign in_ready = en && ust.done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid && in_ready;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= ust.coincide;
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  lal_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk(clk), .en(en), .dist_a(in_dist_a), .dist_b(in_dist_b), .u(ux),
    .a(ax_r), .b(bx_r), .mode(mode_r), .coincide(ust.coincide), .pos(out_pos_x)
  );

  lal_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk(clk), .en(en), .dist_a(in_dist_a), .dist_b(in_dist_b), .u(uy),
    .a(ay_r), .b(by_r), .mode(mode_r), .coincide(ust.coincide), .pos(out_pos_y)
  );

  assign out_valid = v3_r;
  assign out_anchors_coincide = c3_r;

`ifndef NO_ASSERTIONS
  // no transfer while the unit vector is stale
  a_in_needs_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ust.done) else $error("input taken before unit ready");
  // a register write restarts the sequencer
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready) else $error("input open right after config write");
  // a stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  // a stalled pipeline takes no new item
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready) else $error("input taken on stall");
`endif
endmodule

// ===== sv/lal_unit.sv =====
// unit vector sequencer: squares, bit-serial root and two restoring dividers
`timescale 1ns / 1ps
module lal_unit import lal_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int UW = FRAC_BITS + 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [COORD_W-1:0] a_x,
  input  logic signed [COORD_W-1:0] a_y,
  input  logic signed [COORD_W-1:0] b_x,
  input  logic signed [COORD_W-1:0] b_y,
  output logic [UW-1:0]             u_x,
  output logic [UW-1:0]             u_y,
  output unit_status_t              status
);
  localparam int NUMW = DIFF_W + FRAC_BITS + 1;
  localparam int CW   = $clog2(NUMW + 1);
  localparam int LW   = DIFF_W + 1;

  unit_state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [SQ_W-1:0] sq_r, sq_nxt, prod_r, prod_nxt;
  logic [SQ_W-1:0] s_r, s_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [NUMW-1:0] numx_r, numx_nxt, numy_r, numy_nxt;
  logic [NUMW-1:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic [LW:0]     remx_r, remx_nxt, remy_r, remy_nxt;

  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0] magx, magy;
  logic [SQ_W-1:0] trial;
  logic [LW-1:0] len_fin;
  logic [LW:0] rx2, ry2;

  // axis differences and magnitudes
  assign dx = DIFF_W'(b_x) - DIFF_W'(a_x);
  assign dy = DIFF_W'(b_y) - DIFF_W'(a_y);
  assign magx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign magy = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  assign trial = res_r + bit_r;
  assign len_fin = LW'(res_r) + LW'(s_r > res_r);
  assign rx2 = {remx_r[LW-1:0], numx_r[NUMW-1]};
  assign ry2 = {remy_r[LW-1:0], numy_r[NUMW-1]};

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_SQX;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    sq_r <= sq_nxt; prod_r <= prod_nxt;
    s_r <= s_nxt; res_r <= res_nxt; bit_r <= bit_nxt;
    len_r <= len_nxt;
    numx_r <= numx_nxt; numy_r <= numy_nxt;
    qx_r <= qx_nxt; qy_r <= qy_nxt;
    remx_r <= remx_nxt; remy_r <= remy_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r;
    sq_nxt = sq_r; prod_nxt = prod_r;
    s_nxt = s_r; res_nxt = res_r; bit_nxt = bit_r;
    len_nxt = len_r;
    numx_nxt = numx_r; numy_nxt = numy_r;
    qx_nxt = qx_r; qy_nxt = qy_r;
    remx_nxt = remx_r; remy_nxt = remy_r;
    unique case (state_r)
      U_SQX: begin
        sq_nxt = SQ_W'(magx) * SQ_W'(magx);
        state_nxt = U_SQY;
      end
      U_SQY: begin
        prod_nxt = SQ_W'(magy) * SQ_W'(magy);
        state_nxt = U_SUM;
      end
      U_SUM: begin
        s_nxt = sq_r + prod_r;
        res_nxt = '0;
        bit_nxt = SQ_W'(1) << (2 * (ROOT_STEPS - 1));
        cnt_nxt = '0;
        state_nxt = U_SQRT;
      end
      U_SQRT: begin
        if (s_r >= trial) begin
          s_nxt = s_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(ROOT_STEPS - 1)) begin
          state_nxt = U_DIV;
          cnt_nxt = '0;
        end
      end
      U_DIV: begin
        // first cycle here closes the root rounding and loads numerators
        if (cnt_r == '0) begin
          len_nxt = len_fin;
          numx_nxt = ({NUMW'(magx)} << FRAC_BITS) + NUMW'(len_fin >> 1);
          numy_nxt = ({NUMW'(magy)} << FRAC_BITS) + NUMW'(len_fin >> 1);
          remx_nxt = '0; remy_nxt = '0;
          qx_nxt = '0; qy_nxt = '0;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          numx_nxt = numx_r << 1;
          numy_nxt = numy_r << 1;
          if (rx2 >= {1'b0, len_r}) begin
            remx_nxt = rx2 - {1'b0, len_r};
            qx_nxt = {qx_r[NUMW-2:0], 1'b1};
          end else begin
            remx_nxt = rx2;
            qx_nxt = {qx_r[NUMW-2:0], 1'b0};
          end
          if (ry2 >= {1'b0, len_r}) begin
            remy_nxt = ry2 - {1'b0, len_r};
            qy_nxt = {qy_r[NUMW-2:0], 1'b1};
          end else begin
            remy_nxt = ry2;
            qy_nxt = {qy_r[NUMW-2:0], 1'b0};
          end
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CW'(NUMW)) state_nxt = U_DONE;
        end
      end
      U_DONE: ;
      default: state_nxt = U_SQX;
    endcase
    if (start) begin
      state_nxt = U_SQX;
      cnt_nxt = '0;
    end
  end

  assign u_x = qx_r[UW-1:0];
  assign u_y = qy_r[UW-1:0];
  assign status.done = (state_r == U_DONE);
  assign status.coincide = (dx == '0) && (dy == '0);
endmodule

// ===== sv/lal_axis.sv =====
// three stage datapath for one axis: offsets, estimate select, round and saturate
`timescale 1ns / 1ps
module lal_axis import lal_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int UW = FRAC_BITS + 2
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [DIST_W-1:0]         dist_a,
  input  logic [DIST_W-1:0]         dist_b,
  input  logic [UW-1:0]             u,
  input  logic signed [COORD_W-1:0] a,
  input  logic signed [COORD_W-1:0] b,
  input  mode_t                     mode,
  input  logic                      coincide,
  output logic signed [POS_W-1:0]   pos
);
  localparam int OW = DIST_W + UW;
  localparam int PW = FRAC_BITS + 30;
  localparam logic signed [PW-1:0] PMAX = PW'((64'sd1 <<< (POS_W - 1)) - 1);
  localparam logic signed [PW-1:0] PMIN = -PW'(64'sd1 <<< (POS_W - 1));

  logic [OW-1:0] offa_r, offb_r;
  logic signed [PW-1:0] v_r, v_nxt;
  logic k1_r, k1_nxt;
  logic signed [POS_W-1:0] pos_r;

  logic signed [PW-1:0] a_sc, b_sc, oa, ob, pa, pb, t, sh, rnd;

  // stage one: distance times unit component
  always_ff @(posedge clk) begin
    if (en) begin
      offa_r <= OW'(dist_a) * OW'(u);
      offb_r <= OW'(dist_b) * OW'(u);
    end
  end

  // stage two: both estimates and the chosen value
  always_comb begin
    a_sc = PW'(a) <<< FRAC_BITS;
    b_sc = PW'(b) <<< FRAC_BITS;
    oa = $signed(PW'(offa_r));
    ob = $signed(PW'(offb_r));
    if (b > a) begin
      pa = a_sc + oa;
      pb = b_sc - ob;
    end else begin
      pa = a_sc - oa;
      pb = b_sc + ob;
    end
    k1_nxt = 1'b0;
    if (coincide) begin
      v_nxt = a_sc;
    end else begin
      case (mode)
        MODE_A: v_nxt = pa;
        MODE_B: v_nxt = pb;
        default: begin
          v_nxt = pa + pb;
          k1_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
      k1_r <= k1_nxt;
    end
  end

  // stage three: round to nearest, ties up, then clamp
  always_comb begin
    t = k1_r ? v_r + (PW'(1) <<< FRAC_BITS) : v_r + (PW'(1) <<< (FRAC_BITS - 1));
    sh = k1_r ? (t >>> (FRAC_BITS + 1)) : (t >>> FRAC_BITS);
    if (sh > PMAX) rnd = PMAX;
    else if (sh < PMIN) rnd = PMIN;
    else rnd = sh;
  end

  always_ff @(posedge clk) begin
    if (en) pos_r <= rnd[POS_W-1:0];
  end

  assign pos = pos_r;
endmodule

// ===== dv/tb_two_anchor_line_locator.sv =====
// self-checking testbench for the two anchor line locator
`timescale 1ns / 1ps
module tb_two_anchor_line_locator;
  import lal_pkg::*;

  localparam int F = FRAC_BITS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
  localparam longint POS_HI = 33554431;
  localparam longint POS_LO = -33554432;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    coin;
  } fix_t;

  typedef struct {
    bit          cfg;
    int          ax, ay, bx, by;
    logic [1:0]  mode;
    logic [23:0] da, db;
    bit          typed;
    int          ex, ey;
    bit          ec;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [DIST_W-1:0] in_dist_a = '0;
  logic [DIST_W-1:0] in_dist_b = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [POS_W-1:0] out_pos_x, out_pos_y;
  logic out_anchors_coincide;

  // predictor copy of the registers
  longint anc_ax, anc_ay, anc_bx, anc_by;
  logic [1:0] est_mode;

  fix_t pending_fixes[$];
  int   mismatches = 0;
  bit   quiet = 0;
  bit   long_hold_req = 0;
  bit   use_typed = 0;
  fix_t typed_fix;

  two_anchor_line_locator DUT (.*);

  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // integer square root, floor
  function automatic longint unsigned floor_root(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp26(longint v);
    if (v > POS_HI) v = POS_HI;
    if (v < POS_LO) v = POS_LO;
    return v[POS_W-1:0];
  endfunction

  // round to nearest, ties up, then saturate
  function automatic logic signed [POS_W-1:0] round_clamp(longint v, int k);
    return clamp26((v + (longint'(1) <<< (k - 1))) >>> k);
  endfunction

  function automatic logic signed [POS_W-1:0] axis_estimate(longint a, longint b, longint u,
                                                             longint da, longint db);
    longint pa, pb;
    if (b > a) begin
      pa = a * (longint'(1) << F) + da * u;
      pb = b * (longint'(1) << F) - db * u;
    end else begin
      pa = a * (longint'(1) << F) - da * u;
      pb = b * (longint'(1) << F) + db * u;
    end
    if (est_mode == MODE_A) return round_clamp(pa, F);
    if (est_mode == MODE_B) return round_clamp(pb, F);
    return round_clamp(pa + pb, F + 1);
  endfunction

  function automatic fix_t locate_tag(longint da, longint db);
    fix_t r;
    longint dx, dy, ux, uy;
    longint unsigned s, len;
    dx = anc_bx - anc_ax;
    dy = anc_by - anc_ay;
    if (dx == 0 && dy == 0) begin
      r.x = clamp26(anc_ax);
      r.y = clamp26(anc_ay);
      r.coin = 1;
      return r;
    end
    s = dx * dx + dy * dy;
    len = floor_root(s);
    if (s - len * len > len) len++;
    ux = (((dx < 0 ? -dx : dx) << F) + (len >> 1)) / len;
    uy = (((dy < 0 ? -dy : dy) << F) + (len >> 1)) / len;
    r.x = axis_estimate(anc_ax, anc_bx, ux, da, db);
    r.y = axis_estimate(anc_ay, anc_by, uy, da, db);
    r.coin = 0;
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_AX:   anc_ax = longint'($signed(v));
      REG_AY:   anc_ay = longint'($signed(v));
      REG_BX:   anc_bx = longint'($signed(v));
      REG_BY:   anc_by = longint'($signed(v));
      REG_MODE: est_mode = v[1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_anchors(int ax, int ay, int bx, int by, logic [1:0] m);
    write_reg(REG_AX, ax[23:0]);
    write_reg(REG_AY, ay[23:0]);
    write_reg(REG_BX, bx[23:0]);
    write_reg(REG_BY, by[23:0]);
    write_reg(REG_MODE, {22'($urandom), m});
    // unmapped index must be ignored
    write_reg(REG_SPARE, 24'($urandom));
  endtask

  // one input transfer, with an optional idle burst ahead of it
  task automatic send_item(logic [23:0] da, logic [23:0] db);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1;
    in_dist_a <= da;
    in_dist_b <= db;
    do @(posedge clk); while (!in_ready);
    pending_fixes.push_back(use_typed ? typed_fix : locate_tag(da, db));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_fixes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // receiver stalls
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 18);
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // result check
  always @(posedge clk) begin
    fix_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_fixes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d y=%0d", out_pos_x, out_pos_y);
      end else begin
        e = pending_fixes.pop_front();
        if (out_pos_x !== e.x || out_pos_y !== e.y || out_anchors_coincide !== e.coin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp x=%0d y=%0d c=%0b got x=%0d y=%0d c=%0b",
                     e.x, e.y, e.coin, out_pos_x, out_pos_y, out_anchors_coincide);
        end
      end
    end
  end

  row_t rows[] = '{
    // after reset: anchors at origin, so coincident
    '{0, 0, 0, 0, 0, MODE_MEAN, 24'd1234, 24'd99, 1, 0, 0, 1},
    '{0, 0, 0, 0, 0, MODE_MEAN, 24'hFFFFFF, 24'hFFFFFF, 1, 0, 0, 1},
    // coincident anchors at the extremes, modes A, B and reserved
    '{1, 8388607, 8388607, 8388607, 8388607, MODE_A, 24'hFFFFFF, 24'd0,
      1, 8388607, 8388607, 1},
    '{1, -8388608, -8388608, -8388608, -8388608, MODE_B, 24'd0, 24'hFFFFFF,
      1, -8388608, -8388608, 1},
    '{1, -8388608, 8388607, -8388608, 8388607, MODE_RSVD, 24'h555555, 24'hAAAAAA,
      1, -8388608, 8388607, 1},
    // shared y axis, shared x axis
    '{1, 0, 500, 1000, 500, MODE_MEAN, 24'd400, 24'd600, 0, 0, 0, 0},
    '{1, -70, 0, -70, -3000, MODE_MEAN, 24'd1000, 24'd2001, 0, 0, 0, 0},
    // diagonal, each mode
    '{1, 0, 0, 3000, 4000, MODE_MEAN, 24'd2500, 24'd2500, 0, 0, 0, 0},
    '{1, 0, 0, 3000, 4000, MODE_A, 24'd2501, 24'd2499, 0, 0, 0, 0},
    '{1, 0, 0, 3000, 4000, MODE_B, 24'd1, 24'd7, 0, 0, 0, 0},
    '{1, 0, 0, 3000, 4000, MODE_RSVD, 24'd3, 24'd1, 0, 0, 0, 0},
    // B below A on both axes
    '{1, 500, 800, -200, -900, MODE_MEAN, 24'd0, 24'd0, 0, 0, 0, 0},
    '{1, 500, 800, -200, -900, MODE_A, 24'hFFFFFF, 24'd0, 0, 0, 0, 0},
    // widest spans, with the largest distances to one or both anchors
    '{1, -8388608, -8388608, 8388607, 8388607, MODE_A, 24'hFFFFFF, 24'hFFFFFF,
      0, 0, 0, 0},
    '{1, 8388607, -8388608, -8388608, 8388607, MODE_B, 24'hFFFFFF, 24'hFFFFFF,
      0, 0, 0, 0},
    '{1, 8388607, 8388607, -8388608, -8388608, MODE_MEAN, 24'hFFFFFF, 24'd1,
      0, 0, 0, 0},
    // anchors one millimetre apart
    '{1, 0, 0, 1, 0, MODE_MEAN, 24'd1, 24'd0, 0, 0, 0, 0},
    '{1, 5, 5, 5, 4, MODE_B, 24'h800000, 24'h7FFFFF, 0, 0, 0, 0}
  };

  initial begin
    int ax, ay, bx, by, span, kind;
    logic [23:0] da, db;
    anc_ax = 0; anc_ay = 0; anc_bx = 0; anc_by = 0;
    est_mode = MODE_MEAN;
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // directed table
    foreach (rows[i]) begin
      if (rows[i].cfg)
        set_anchors(rows[i].ax, rows[i].ay, rows[i].bx, rows[i].by, rows[i].mode);
      use_typed = rows[i].typed;
      typed_fix.x = POS_W'(rows[i].ex);
      typed_fix.y = POS_W'(rows[i].ey);
      typed_fix.coin = rows[i].ec;
      send_item(rows[i].da, rows[i].db);
      drain();
    end
    use_typed = 0;

    // random phases, a fresh anchor set each
    for (int p = 0; p < 12; p++) begin
      kind = $urandom_range(0, 4);
      span = (kind == 0) ? 2000 : 8388607;
      ax = $urandom_range(0, 2 * span) - span;
      ay = $urandom_range(0, 2 * span) - span;
      bx = $urandom_range(0, 2 * span) - span;
      by = $urandom_range(0, 2 * span) - span;
      if (kind == 2) by = ay;
      if (kind == 3) bx = ax;
      if (p == 5) begin
        bx = ax;
        by = ay;
      end
      quiet = (p >= 10);
      set_anchors(ax, ay, bx, by, p < 4 ? 2'(p) : 2'($urandom));
      // fill the pipe against a stalled receiver
      if (p == 3) long_hold_req = 1;
      for (int n = 0; n < 85; n++) begin
        if ($urandom_range(0, 1) == 0) begin
          da = 24'($urandom);
          db = 24'($urandom);
        end else begin
          da = 24'($urandom_range(0, 40000));
          db = 24'($urandom_range(0, 40000));
        end
        if (p == 3) begin
          in_valid <= 1;
          in_dist_a <= da;
          in_dist_b <= db;
          do @(posedge clk); while (!in_ready);
          pending_fixes.push_back(locate_tag(da, db));
        end else begin
          send_item(da, db);
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/lal_pkg.sv
sv/lal_unit.sv
sv/lal_axis.sv
sv/two_anchor_line_locator.sv
dv/tb_two_anchor_line_locator.sv
